FILE: hw/rtl/byte_frame_rotate_clockwise_defines.svh
// assertion macros shared by the rotate block
`ifndef BYTE_FRAME_ROTATE_CLOCKWISE_DEFINES_SVH
`define BYTE_FRAME_ROTATE_CLOCKWISE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BFRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bfrc_pkg.sv
`timescale 1ns / 1ps

package bfrc_pkg;

    localparam int MAX_PIXELS_DEF = 4096;

    // header layout
    localparam logic [31:0] HDR_BYTES   = 32'd8;
    localparam logic [31:0] HALF_HDR    = 32'd4;
    localparam logic [3:0]  PH_LAST_HDR = 4'd7;
    localparam logic [3:0]  PH_PIX      = 4'd8;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } out_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic ld;         // store one load byte
        logic chk;        // size check, emit load status
        logic hdr;        // emit one rotated header byte
        logic pix_rd;     // issue a pixel read, advance position
        logic emit_pix;   // emit the pixel read last cycle
        logic emit_none;  // emit no-frame status
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic ready;      // a valid frame is held
        logic pix_phase;  // read position is in the pixel part
    } dp_stat_t;

endpackage

FILE: hw/rtl/bfrc_ram.sv
`timescale 1ns / 1ps

module bfrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfrc_pkg::MAX_PIXELS_DEF
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hw/rtl/bfrc_dp.sv
`timescale 1ns / 1ps

module bfrc_dp #(
    parameter int MAX_PIXELS = bfrc_pkg::MAX_PIXELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfrc_pkg::in_item_t   in_item,
    input  bfrc_pkg::ctl_t       ctl,
    output bfrc_pkg::dp_stat_t   stat,
    output bfrc_pkg::out_item_t  out_item
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [31:0] MAX_W = 32'(MAX_PIXELS);
    localparam logic [63:0] MAX_P = 64'(MAX_PIXELS);

    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] count_reg, count_next;
    logic [63:0] prod_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] row_reg, row_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] base_reg, base_next;
    logic        ready_reg, ready_next;
    logic        tzero_reg, tzero_next;
    logic        fin_reg, fin_next;
    bfrc_pkg::out_item_t out_item_reg, out_item_next;

    logic          cnt_zero;
    logic [31:0]   pix;
    logic [31:0]   w_base, h_base;
    logic [31:0]   hdr_word;
    logic [7:0]    hdr_byte;
    logic [AW:0]   col_inc;
    logic          size_ok;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    bfrc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_item.data_byte),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        ready_next    = ready_reg;
        tzero_next    = tzero_reg;
        fin_next      = fin_reg;
        out_item_next = out_item_reg;
        ram_we        = 1'b0;
        ram_addr      = idx_reg;

        cnt_zero = (count_reg == 32'd0);
        pix      = count_reg - bfrc_pkg::HDR_BYTES;
        w_base   = cnt_zero ? 32'd0 : width_reg;
        h_base   = cnt_zero ? 32'd0 : height_reg;
        col_inc  = {1'b0, col_reg} + (AW+1)'(1);

        // height first, then width, each big-endian
        hdr_word = phase_reg[2] ? width_reg : height_reg;
        case (phase_reg[1:0])
            2'd0:    hdr_byte = hdr_word[31:24];
            2'd1:    hdr_byte = hdr_word[23:16];
            2'd2:    hdr_byte = hdr_word[15:8];
            default: hdr_byte = hdr_word[7:0];
        endcase

        size_ok = (count_reg >= bfrc_pkg::HDR_BYTES) && ({32'd0, pix} == prod_reg)
                  && (prod_reg <= MAX_P);

        if (ctl.ld)
        begin
            // first byte of a new frame drops the held one
            if (cnt_zero)
            begin
                ready_next = 1'b0;
                phase_next = '0;
                col_next   = '0;
                row_next   = '0;
            end
            width_next  = w_base;
            height_next = h_base;
            if (count_reg < bfrc_pkg::HALF_HDR)
            begin
                width_next = {w_base[23:0], in_item.data_byte};
            end
            else if (count_reg < bfrc_pkg::HDR_BYTES)
            begin
                height_next = {h_base[23:0], in_item.data_byte};
            end
            else if (pix < MAX_W)
            begin
                ram_we   = 1'b1;
                ram_addr = pix[AW-1:0];
            end
            if (count_reg != '1)
            begin
                count_next = count_reg + 32'd1;
            end
        end

        if (ctl.chk)
        begin
            ready_next = size_ok;
            tzero_next = (prod_reg == 64'd0);
            // index of the bottom-left pixel
            base_next  = prod_reg[AW-1:0] - width_reg[AW-1:0];
            count_next = '0;
            phase_next = '0;
            col_next   = '0;
            row_next   = '0;
            out_item_next.out_byte = 8'd0;
            out_item_next.out_last = 1'b0;
            out_item_next.status   = size_ok ? bfrc_pkg::STATUS_OK
                                             : bfrc_pkg::STATUS_BAD_SIZE;
        end

        if (ctl.hdr)
        begin
            out_item_next.out_byte = hdr_byte;
            out_item_next.out_last = (phase_reg == bfrc_pkg::PH_LAST_HDR) && tzero_reg;
            out_item_next.status   = bfrc_pkg::STATUS_OK;
            if (phase_reg == bfrc_pkg::PH_LAST_HDR)
            begin
                if (tzero_reg)
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = bfrc_pkg::PH_PIX;
                    col_next   = '0;
                    row_next   = height_reg[AW-1:0] - AW'(1);
                    idx_next   = base_reg;
                end
            end
            else
            begin
                phase_next = phase_reg + 4'd1;
            end
        end

        if (ctl.pix_rd)
        begin
            ram_addr = idx_reg;
            fin_next = (32'(col_reg) == width_reg - 32'd1) && (row_reg == '0);
            if (row_reg == '0)
            begin
                // top of a column: next column, bottom row
                row_next = height_reg[AW-1:0] - AW'(1);
                col_next = col_inc[AW-1:0];
                idx_next = idx_reg + base_reg + AW'(1);
                if (32'(col_inc) >= width_reg)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    phase_next = '0;
                end
            end
            else
            begin
                row_next = row_reg - AW'(1);
                idx_next = idx_reg - width_reg[AW-1:0];
            end
        end

        if (ctl.emit_pix)
        begin
            out_item_next.out_byte = ram_rdata;
            out_item_next.out_last = fin_reg;
            out_item_next.status   = bfrc_pkg::STATUS_OK;
        end

        if (ctl.emit_none)
        begin
            out_item_next.out_byte = 8'd0;
            out_item_next.out_last = 1'b0;
            out_item_next.status   = bfrc_pkg::STATUS_NO_FRAME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ready_reg  <= 1'b0;
            tzero_reg  <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ready_reg  <= ready_next;
            tzero_reg  <= tzero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= width_reg * height_reg;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        fin_reg      <= fin_next;
        out_item_reg <= out_item_next;
    end

    assign stat.ready     = ready_reg;
    assign stat.pix_phase = phase_reg[3];
    assign out_item       = out_item_reg;

endmodule

FILE: hw/rtl/bfrc_ctrl.sv
`timescale 1ns / 1ps
`include "byte_frame_rotate_clockwise_defines.svh"

module bfrc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfrc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    input  bfrc_pkg::dp_stat_t  stat,
    output bfrc_pkg::ctl_t      ctl
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_RD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   acc;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (in_item.cmd == bfrc_pkg::CMD_LOAD)
                    begin
                        ctl.ld = 1'b1;
                        if (in_item.last)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    else if (!stat.ready)
                    begin
                        ctl.emit_none = 1'b1;
                    end
                    else if (stat.pix_phase)
                    begin
                        ctl.pix_rd = 1'b1;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        ctl.hdr = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                ctl.chk    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                ctl.emit_pix = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (ctl.chk || ctl.hdr || ctl.emit_pix || ctl.emit_none)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BFRC_ASSERT_NEXT(a_mul_then_chk, state_reg == ST_MUL, state_reg == ST_CHK, "check must follow multiply")
    `BFRC_ASSERT_NEXT(a_rd_emits, state_reg == ST_RD, out_valid_reg, "pixel read gave no result")
    `BFRC_ASSERT_NEXT(a_last_load_busy, acc && (in_item.cmd == bfrc_pkg::CMD_LOAD) && in_item.last, (state_reg == ST_MUL) && !out_valid_reg, "final load did not start check")
    `BFRC_ASSERT_NOW(a_busy_no_accept, state_reg != ST_IDLE, !in_ready, "item taken while busy")

endmodule

FILE: hw/rtl/byte_frame_rotate_clockwise.sv
// byte frame rotate, 90 degrees clockwise
// input channel (in_valid / in_ready / in_item): each item is a load byte
// (cmd load, data_byte, last) or a read request (cmd read)
// a frame is an 8-byte header, width then height, 32-bit big-endian, then
// width*height row-major pixel bytes; last marks the final byte
// output channel (out_valid / out_ready / out_item): one item per read, and
// one status item per load that carries last; plain loads give nothing
// reads return the header with height and width swapped, then the pixels
// column by column from the bottom row up, out_last on the final byte
// a size mismatch or a frame over MAX_PIXELS is flagged and never emitted
// a header read gives its item in the cycle after acceptance, a pixel read
// goes through the registered store read and then the output register, and
// the final load through the registered 32x32 size product, then compare
// one item is in flight at a time, so a new item is taken once the previous
// one finishes and the output register is free or being drained
// a stalled receiver holds the output item and blocks further input
// reset clears all control state, no frame is held; the pixel store needs
// no clearing pass as every entry of a valid frame is written before use
`timescale 1ns / 1ps

module byte_frame_rotate_clockwise #(
    parameter int MAX_PIXELS = bfrc_pkg::MAX_PIXELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bfrc_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bfrc_pkg::out_item_t  out_item
);

    // controller to datapath commands and status back
    bfrc_pkg::ctl_t     ctl;
    bfrc_pkg::dp_stat_t stat;

    // sequencing: accept, size check, read wait
    bfrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // header registers, pixel store, rotated address walk, output register
    bfrc_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .ctl      (ctl),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bfrc_pkg::*;

    localparam int STORE_DEPTH     = MAX_PIXELS_DEF;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int TAIL_CYCLES     = 16;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int RANDOM_PER_PACE = 520;

    // idling pattern, one per part of the run
    typedef enum int {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_FULL
    } pace_t;

    typedef struct {
        in_item_t item;
        pace_t    pace;
        bit       drain_first;
        bit       hold_rx;
    } pending_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    byte_frame_rotate_clockwise dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // items still to be offered, and rotated bytes or statuses still owed
    pending_t  pending_items[$];
    out_item_t expected_results[$];

    // state for building the stimulus
    pace_t cur_pace   = PACE_RX_SLOW;
    bit    drain_next = 1'b0;
    bit    hold_next  = 1'b0;

    // handshake bookkeeping shared by the clocked blocks
    bit in_fire    = 1'b0;
    int hold_reqs  = 0;
    int holds_done = 0;
    int hold_left  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int fail_count    = 0;
    int cycle_count   = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int frames_good   = 0;
    int frames_bad    = 0;
    int reads_no_frame = 0;
    int frame_ends    = 0;

    // predictor copy of the frame store and read position
    logic [7:0]  pixel_mem [STORE_DEPTH];
    logic [31:0] hdr_width  = '0;
    logic [31:0] hdr_height = '0;
    logic [31:0] byte_count = '0;
    logic [31:0] rd_col     = '0;
    logic [31:0] rd_row     = '0;
    logic [3:0]  rd_phase   = '0;
    bit          frame_held = 1'b0;

    // ------------------------------------------------------------------
    // predictor: one input item in, at most one result out
    // ------------------------------------------------------------------
    function automatic bit rotate_step(input in_item_t it, output out_item_t res);
        logic [63:0] area;
        logic [63:0] idx;
        logic [31:0] word;
        logic [31:0] payload;
        int          sh;
        bit          ok;
        res = '0;
        if (it.cmd == CMD_LOAD)
        begin
            // first byte of a new frame drops whatever was held
            if (byte_count == 0)
            begin
                frame_held = 1'b0;
                hdr_width  = '0;
                hdr_height = '0;
                rd_phase   = '0;
                rd_col     = '0;
                rd_row     = '0;
            end
            if (byte_count < HALF_HDR)
                hdr_width = {hdr_width[23:0], it.data_byte};
            else if (byte_count < HDR_BYTES)
                hdr_height = {hdr_height[23:0], it.data_byte};
            else
            begin
                payload = byte_count - HDR_BYTES;
                // bytes beyond the store are counted, not kept
                if (payload < STORE_DEPTH)
                    pixel_mem[payload[11:0]] = it.data_byte;
            end
            if (byte_count != '1)
                byte_count++;
            if (!it.last)
                return 1'b0;
            area = 64'(hdr_width) * 64'(hdr_height);
            ok = 1'b0;
            if (byte_count >= HDR_BYTES)
            begin
                payload = byte_count - HDR_BYTES;
                ok = ({32'd0, payload} == area) && (area <= STORE_DEPTH);
            end
            frame_held = ok;
            byte_count = '0;
            rd_phase   = '0;
            rd_col     = '0;
            rd_row     = '0;
            res.status = ok ? STATUS_OK : STATUS_BAD_SIZE;
            return 1'b1;
        end

        if (!frame_held)
        begin
            res.status = STATUS_NO_FRAME;
            return 1'b1;
        end

        area = 64'(hdr_width) * 64'(hdr_height);
        if (rd_phase < PH_PIX)
        begin
            // header goes out with height first, then width
            word = (rd_phase < 4) ? hdr_height : hdr_width;
            sh = 8 * (3 - int'(rd_phase[1:0]));
            res.out_byte = word[sh +: 8];
            res.out_last = (rd_phase == PH_LAST_HDR) && (area == 0);
            res.status   = STATUS_OK;
            rd_phase++;
            if (rd_phase == PH_PIX)
            begin
                if (area == 0)
                    rd_phase = '0;
                else
                begin
                    rd_col = '0;
                    rd_row = hdr_height - 1;
                end
            end
        end
        else
        begin
            idx = 64'(rd_row) * 64'(hdr_width) + 64'(rd_col);
            res.out_byte = pixel_mem[idx[11:0]];
            res.out_last = (rd_col == hdr_width - 1) && (rd_row == 0);
            res.status   = STATUS_OK;
            // walk up the column, then step right to the next bottom row
            if (rd_row == 0)
            begin
                rd_row = hdr_height - 1;
                rd_col++;
                if (rd_col >= hdr_width)
                begin
                    rd_col   = '0;
                    rd_row   = '0;
                    rd_phase = '0;
                end
            end
            else
                rd_row--;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input logic c, input logic [7:0] b, input logic l);
        pending_t p;
        p.item.cmd       = c;
        p.item.data_byte = b;
        p.item.last      = l;
        p.pace           = cur_pace;
        p.drain_first    = drain_next;
        p.hold_rx        = hold_next;
        drain_next = 1'b0;
        hold_next  = 1'b0;
        pending_items.push_back(p);
    endtask

    // read requests carry random filler in the ignored fields
    task automatic push_reads(input int n);
        for (int i = 0; i < n; i++)
            push_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // header then len pixel bytes, last on the final byte; mix_pct slips
    // reads in between the loads
    task automatic push_frame(input logic [31:0] w, input logic [31:0] h,
                              input int len, input int mix_pct);
        logic [63:0] hdr;
        int          total;
        hdr   = {w, h};
        total = 8 + len;
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(99) < mix_pct)
                push_reads(1);
            push_item(CMD_LOAD,
                      (i < 8) ? hdr[63 - 8 * i -: 8] : 8'($urandom_range(255)),
                      i == total - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // input driver: new item at the falling edge once the last one is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_inputs
        pending_t nxt;
        logic     offer;
        if (rst_n && (!in_valid || in_fire))
        begin
            offer = 1'b0;
            if (pending_items.size() != 0)
            begin
                nxt = pending_items[0];
                // the pace of the next item sets idling on both sides
                case (nxt.pace)
                    PACE_RX_SLOW:
                    begin
                        tx_idle_pct = 22;
                        rx_idle_pct = 70;
                    end
                    PACE_TX_SLOW:
                    begin
                        tx_idle_pct = 70;
                        rx_idle_pct = 22;
                    end
                    default:
                    begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                // a drain mark holds the item back until nothing is owed
                if (!(nxt.drain_first && expected_results.size() != 0) &&
                    $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    in_item <= nxt.item;
                    offer = 1'b1;
                    if (nxt.hold_rx)
                        hold_reqs++;
                end
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (holds_done != hold_reqs)
            begin
                holds_done = hold_reqs;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then predict for the item taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t prediction;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %0d out_last %0d status %0d",
                           out_item.out_byte, out_item.out_last, out_item.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0d, actual %0d",
                               want.out_byte, out_item.out_byte);
                        fail_count++;
                    end
                    if (out_item.out_last !== want.out_last)
                    begin
                        $error("out_last: expected %0d, actual %0d",
                               want.out_last, out_item.out_last);
                        fail_count++;
                    end
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_item.status);
                        fail_count++;
                    end
                end
                if (out_item.out_last === 1'b1)
                    frame_ends++;
            end
            if (in_fire)
            begin
                items_taken++;
                if (rotate_step(in_item, prediction))
                begin
                    expected_results.push_back(prediction);
                    if (in_item.cmd == CMD_LOAD && prediction.status == STATUS_OK)
                        frames_good++;
                    else if (prediction.status == STATUS_BAD_SIZE)
                        frames_bad++;
                    else if (prediction.status == STATUS_NO_FRAME)
                        reads_no_frame++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : run_control
        int kind;
        int w;
        int h;
        int n;
        int len;
        int target;
        rst_n = 1'b0;

        // directed: read with nothing held, short header, empty frame
        cur_pace = PACE_RX_SLOW;
        push_reads(1);
        for (int i = 0; i < 3; i++)
            push_item(CMD_LOAD, 8'($urandom_range(255)), i == 2);
        push_reads(1);
        // zero width: header alone, last on its eighth byte, then wraps
        push_frame(32'd0, 32'd3, 0, 0);
        push_reads(9);

        // random part, one stretch per pace, sender drains between them
        for (int ph = 0; ph < 3; ph++)
        begin
            cur_pace = pace_t'(ph);
            if (ph > 0)
                drain_next = 1'b1;
            target = pending_items.size() + RANDOM_PER_PACE;
            while (pending_items.size() < target)
            begin
                kind = $urandom_range(99);
                w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
                h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
                n = w * h;
                if (kind < 55)
                begin
                    // well-formed frame, read fully, twice over, or in part
                    push_frame(w, h, n, 0);
                    case ($urandom_range(2))
                        0: push_reads(8 + n);
                        1: push_reads(2 * (8 + n) + $urandom_range(3));
                        default: push_reads($urandom_range(8 + n));
                    endcase
                end
                else if (kind < 68)
                begin
                    // payload short of or beyond width*height
                    if (n > 0 && $urandom_range(1) == 1)
                        len = $urandom_range(n - 1);
                    else
                        len = n + 1 + $urandom_range(3);
                    push_frame(w, h, len, 0);
                    push_reads($urandom_range(1, 3));
                end
                else if (kind < 76)
                begin
                    // last mark inside the header
                    len = $urandom_range(1, 7);
                    for (int i = 0; i < len; i++)
                        push_item(CMD_LOAD, 8'($urandom_range(255)), i == len - 1);
                    push_reads($urandom_range(1, 3));
                end
                else if (kind < 84)
                begin
                    // random header words, mostly far too large
                    push_frame($urandom, $urandom, $urandom_range(6), 0);
                    push_reads(2);
                end
                else if (kind < 93)
                begin
                    // reads mixed into the load
                    push_frame(w, h, n, 20);
                    push_reads(8 + n);
                end
                else
                    push_reads($urandom_range(1, 4));
            end
        end

        // extremes at full pace
        push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        push_reads(2);
        // receiver holds off while reads pile up behind one result
        drain_next = 1'b1;
        push_frame(32'd2, 32'd40, 80, 0);
        hold_next = 1'b1;
        push_reads(8 + 80);
        push_frame(32'd1, 32'd1, 1, 0);
        push_reads(18);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d items in, %0d results out over %0d cycles",
                 items_taken, results_seen, cycle_count);
        $display("run: %0d frames held, %0d flagged, %0d reads with no frame, %0d ends",
                 frames_good, frames_bad, reads_no_frame, frame_ends);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
